/* rtl/core/bce_pkg.sv */
// bce_pkg: shared types and constants for the binomial coefficient engine
// used by bce_datapath, bce_ctrl and binomial_coefficient_engine_core
`default_nettype none

package bce_pkg;

    // width of the n and k fields and of the column counter; the row counter is one bit wider
    localparam int CNT_W = 7;
    // largest n the field can carry
    localparam int N_LIMIT = (1 << CNT_W) - 1;
    // coefficient width and saturation value
    localparam int COEF_W = 63;
    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

    // commands from the controller to the datapath
    typedef struct packed {
        logic             wr_en;          // write one row store entry
        logic             wr_one;         // write data is 1 instead of the sum
        logic [CNT_W-1:0] wr_addr;
        logic [CNT_W-1:0] rd_addr;        // row store read, data registered for the next cycle
        logic             hold_load;      // keep read data as the upper operand
        logic             sum_en;         // a sum is written this cycle
        logic             ovf_clear;      // start of a request
        logic             out_load_mem;   // result from the row store read data
        logic             out_load_const; // result is zero with const_ovf
        logic             const_ovf;
    } bce_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/bce_datapath.sv */
// bce_datapath: row store memory, saturating adder and result registers
// depends on bce_pkg; driven by bce_ctrl through bce_cmd_t
`default_nettype none

module bce_datapath
    import bce_pkg::*;
#(
    parameter int MAX_N = 127
)
(
    input  wire logic              clk,
    input  wire bce_cmd_t          cmd,
    output logic [COEF_W-1:0]      coefficient,
    output logic                   overflow
);

    localparam int ROW_DEPTH = ((MAX_N < N_LIMIT) ? MAX_N : N_LIMIT) + 1;
    localparam int ADDR_W    = $clog2(ROW_DEPTH);

    logic [COEF_W-1:0] row_mem [ROW_DEPTH];
    logic [COEF_W-1:0] rd_data_reg;
    logic [COEF_W-1:0] hold_reg;
    logic              ovf_reg;
    logic [COEF_W-1:0] coefficient_reg;
    logic              overflow_reg;
    logic [COEF_W:0]   sum;
    logic              sat;
    logic [COEF_W-1:0] wr_data;

    // old[j-1] + old[j], clamped to the 63-bit maximum
    assign sum     = {1'b0, rd_data_reg} + {1'b0, hold_reg};
    assign sat     = sum[COEF_W];
    assign wr_data = cmd.wr_one ? COEF_W'(1) : (sat ? COEF_MAX : sum[COEF_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            row_mem[cmd.wr_addr[ADDR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= row_mem[cmd.rd_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_load)
        begin
            hold_reg <= rd_data_reg;
        end
        if (cmd.ovf_clear)
        begin
            ovf_reg <= 1'b0;
        end
        else if (cmd.sum_en && sat)
        begin
            ovf_reg <= 1'b1;
        end
        if (cmd.out_load_mem)
        begin
            coefficient_reg <= rd_data_reg;
            overflow_reg    <= ovf_reg;
        end
        else if (cmd.out_load_const)
        begin
            coefficient_reg <= '0;
            overflow_reg    <= cmd.const_ovf;
        end
    end

    assign coefficient = coefficient_reg;
    assign overflow    = overflow_reg;

endmodule

`default_nettype wire

/* rtl/core/bce_ctrl.sv */
// bce_ctrl: request sequencer walking the Pascal cone row by row
// depends on bce_pkg; issues bce_cmd_t to bce_datapath
`default_nettype none

module bce_ctrl
    import bce_pkg::*;
#(
    parameter int MAX_N = 127
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic [CNT_W-1:0] total_count,
    input  wire logic [CNT_W-1:0] choose_count,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output bce_cmd_t              cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_ROW  = 3'd2;
    localparam logic [2:0] ST_RDLO = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_LOAD = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [9:0] MAX_N_V = 10'(MAX_N);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W:0]   row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;

    logic [CNT_W-1:0] span;
    logic [CNT_W:0]   row_m1;
    logic [CNT_W-1:0] hi;
    logic [CNT_W:0]   lo;
    logic             row_live;
    logic             refuse;

    // column range of the current row inside the cone of C(n,k)
    assign span     = n_reg - k_reg;
    assign row_m1   = row_reg - (CNT_W+1)'(1);
    assign hi       = (row_m1 < {1'b0, k_reg}) ? row_m1[CNT_W-1:0] : k_reg;
    assign lo       = (row_reg > ({1'b0, span} + (CNT_W+1)'(1)))
                      ? (row_reg - {1'b0, span}) : (CNT_W+1)'(1);
    assign row_live = ({1'b0, hi} >= lo);
    assign refuse   = ({3'd0, total_count} > MAX_N_V);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    n_next = total_count;
                    k_next = choose_count;
                    if (refuse)
                    begin
                        cmd.out_load_const = 1'b1;
                        cmd.const_ovf      = 1'b1;
                        state_next         = ST_OUT;
                    end
                    else if (choose_count > total_count)
                    begin
                        cmd.out_load_const = 1'b1;
                        state_next         = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_one    = 1'b1;
                cmd.ovf_clear = 1'b1;
                row_next      = (CNT_W+1)'(1);
                state_next    = ST_ROW;
            end
            ST_ROW:
            begin
                if (row_reg > {1'b0, n_reg})
                begin
                    cmd.rd_addr = k_reg;
                    state_next  = ST_LOAD;
                end
                else
                begin
                    // diagonal edge of the triangle
                    if (row_reg <= {1'b0, k_reg})
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_one  = 1'b1;
                        cmd.wr_addr = row_reg[CNT_W-1:0];
                    end
                    if (row_live)
                    begin
                        col_next    = hi;
                        cmd.rd_addr = hi;
                        state_next  = ST_RDLO;
                    end
                    else
                    begin
                        row_next = row_reg + (CNT_W+1)'(1);
                    end
                end
            end
            ST_RDLO:
            begin
                cmd.hold_load = 1'b1;
                cmd.rd_addr   = col_reg - CNT_W'(1);
                state_next    = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.wr_en     = 1'b1;
                cmd.sum_en    = 1'b1;
                cmd.wr_addr   = col_reg;
                cmd.hold_load = 1'b1;
                if ({1'b0, col_reg} == lo)
                begin
                    row_next   = row_reg + (CNT_W+1)'(1);
                    state_next = ST_ROW;
                end
                else
                begin
                    cmd.rd_addr = col_reg - CNT_W'(2);
                    col_next    = col_reg - CNT_W'(1);
                end
            end
            ST_LOAD:
            begin
                cmd.out_load_mem = 1'b1;
                state_next       = ST_OUT;
            end
            ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        k_reg   <= k_next;
        row_reg <= row_next;
        col_reg <= col_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_OUT);

endmodule

`default_nettype wire

/* rtl/core/binomial_coefficient_engine_core.sv */
// binomial_coefficient_engine_core: top level, C(n,k) by the Pascal rule
// depends on bce_pkg, bce_ctrl and bce_datapath
//
// request channel: req_valid / req_stall with total_count (n) and
// choose_count (k); a transaction completes on a clock edge with req_valid
// high and req_stall low. response channel: rsp_valid / rsp_stall with
// coefficient and overflow, one response per request.
// one request is handled at a time; req_stall stays high from the accepted
// transaction until its response has been taken, the next request is taken
// in the idle cycle after that.
// k > n, or n above MAX_N (refused with overflow set), goes straight to the
// response. otherwise the sequencer runs init, a row step for each row 1..n
// with, for each row that has cone entries, a read step and one add step
// per entry, then a final row check, load and the response.
// overflow is set when any sum feeding C(n,k) went above 2^63 - 1; the
// coefficient then reads 2^63 - 1. reset clears the sequencer to idle; the
// row store is not cleared, every entry is written before it is read.
// a stalled response holds its value and valid until rsp_stall drops.
`default_nettype none

module binomial_coefficient_engine_core
    import bce_pkg::*;
#(
    parameter int MAX_N = 127
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic [CNT_W-1:0] total_count,
    input  wire logic [CNT_W-1:0] choose_count,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output logic [COEF_W-1:0]     coefficient,
    output logic                  overflow
);

    localparam logic [9:0] MAX_N_V = 10'(MAX_N);

    // command bundle from sequencer to datapath
    bce_cmd_t cmd;

    bce_ctrl #(
        .MAX_N (MAX_N)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .total_count  (total_count),
        .choose_count (choose_count),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .cmd          (cmd)
    );

    bce_datapath #(
        .MAX_N (MAX_N)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .coefficient (coefficient),
        .overflow    (overflow)
    );

    // no new request while a response is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request taken while response pending");

    // k above n answers zero without overflow on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && ({3'd0, total_count} <= MAX_N_V)
         && (choose_count > total_count))
        |=> (rsp_valid && (coefficient == '0) && !overflow))
        else $error("k above n not answered with zero");

    // a saturated computation always reports the clamp value
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && overflow && (coefficient != '0)) |-> (coefficient == COEF_MAX))
        else $error("overflow without saturated coefficient");

    // datapath never writes the row store outside an active computation
    assert property (@(posedge clk) disable iff (!rst_n)
        (!req_stall || rsp_valid) |-> !cmd.wr_en)
        else $error("row store written while idle");

endmodule

`default_nettype wire
